// ===== design/lrukv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lrukv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
	localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

	// Register index, taken from the word part of paddr.
	localparam logic CFG_IDX_CAPACITY = 1'b0;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic signed [KEY_W-1:0]    key;
		logic signed [DATA_W-1:0]   value;
	} cache_req_t;

	typedef struct packed {
		logic                       hit;
		logic signed [DATA_W-1:0]   read_value;
		logic                       evicted;
		logic signed [KEY_W-1:0]    evicted_key;
	} cache_rsp_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
//
// Usage:
//   A request word (op, key, value) is taken at a rising edge with start high
//   and busy low. busy is always low, so a request may be issued every cycle.
//   The request is registered, then looked up against all entries: the
//   key compare over every entry, the recency rank update and the free
//   slot search all complete between the request register and the result
//   register. The result word appears on result with done high for
//   exactly one cycle, starting at the edge after the one that took the
//   request; the receiver cannot hold it off. Throughput is one request
//   per cycle, as the lookup and update complete between those two
//   registers; each request sees the state left by the one before it.
//   The capacity register sits at byte address 0 of the APB port and should
//   only be written while no request is in flight.
//   Reset empties the cache (all entries invalid, occupancy zero), sets the
//   capacity to its reset value and drops any request in flight.
module lru_key_value_cache
	import lrukv_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cache_req_t            request,
	output logic                  done,
	output cache_rsp_t            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [CAP_W-1:0] capacity_q;

	logic             valid_s1;
	cache_req_t       req_s1;

	logic [MAX_ENTRIES-1:0]   entry_valid_q;
	logic [KEY_W-1:0]         entry_key_q [MAX_ENTRIES];
	logic [DATA_W-1:0]        entry_value_q [MAX_ENTRIES];
	logic [RANK_W-1:0]        rank_q [MAX_ENTRIES];
	logic [OCC_W-1:0]         occupancy_q;

	logic                     done_q;
	cache_rsp_t               result_q;

	logic [MAX_ENTRIES-1:0]   match_vec;
	logic [MAX_ENTRIES-1:0]   hit_oh;
	logic [MAX_ENTRIES-1:0]   oldest_oh;
	logic [MAX_ENTRIES-1:0]   valid_after_evict;
	logic [MAX_ENTRIES-1:0]   free_vec;
	logic [MAX_ENTRIES-1:0]   slot_oh;
	logic                     found;
	logic [RANK_W-1:0]        found_rank;
	logic [DATA_W-1:0]        found_value;
	logic [KEY_W-1:0]         oldest_key;
	logic [RANK_W-1:0]        last_rank;
	logic [CMP_W-1:0]         cap_ext;
	logic [CMP_W-1:0]         eff_capacity;
	logic                     full;
	logic                     is_put;
	logic                     do_evict;
	logic                     do_insert;

	logic [MAX_ENTRIES-1:0]   entry_valid_d;
	logic [RANK_W-1:0]        rank_d [MAX_ENTRIES];
	logic [OCC_W-1:0]         occupancy_d;
	logic [MAX_ENTRIES-1:0]   key_we;
	logic [MAX_ENTRIES-1:0]   value_we;
	cache_rsp_t               result_d;

	logic                     cfg_write;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[2] == CFG_IDX_CAPACITY);
	assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_write) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign busy = 1'b0;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	// Lookup, victim choice and free slot choice.
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_capacity = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			eff_capacity = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_capacity = cap_ext;
		end
		full = CMP_W'(occupancy_q) >= eff_capacity;
		is_put = (req_s1.op == OP_PUT);

		// Valid ranks always form 0..occupancy-1, so the least recent
		// entry is the one holding rank occupancy-1.
		last_rank = RANK_W'(occupancy_q - OCC_W'(1));

		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_vec[i] = entry_valid_q[i] && (entry_key_q[i] == req_s1.key);
			oldest_oh[i] = entry_valid_q[i] && (rank_q[i] == last_rank);
		end
		hit_oh = match_vec & (~match_vec + MAX_ENTRIES'(1));
		found = |match_vec;

		found_rank = '0;
		found_value = '0;
		oldest_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			found_rank = found_rank | (hit_oh[i] ? rank_q[i] : '0);
			found_value = found_value | (hit_oh[i] ? entry_value_q[i] : '0);
			oldest_key = oldest_key | (oldest_oh[i] ? entry_key_q[i] : '0);
		end

		do_insert = valid_s1 && is_put && !found;
		do_evict = do_insert && full;
		valid_after_evict = entry_valid_q & ~(do_evict ? oldest_oh : '0);
		free_vec = ~valid_after_evict;
		slot_oh = free_vec & (~free_vec + MAX_ENTRIES'(1));
	end

	// Next state of the entries.
	always_comb begin
		entry_valid_d = entry_valid_q;
		occupancy_d = occupancy_q;
		key_we = '0;
		value_we = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end

		if (valid_s1 && found) begin
			// Entries more recent than the hit move back by one.
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (hit_oh[i]) begin
					rank_d[i] = '0;
				end else if (entry_valid_q[i] && (rank_q[i] < found_rank)) begin
					rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
				end
			end
			if (is_put) begin
				value_we = hit_oh;
			end
		end else if (do_insert) begin
			entry_valid_d = valid_after_evict | slot_oh;
			key_we = slot_oh;
			value_we = slot_oh;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (slot_oh[i]) begin
					rank_d[i] = '0;
				end else if (valid_after_evict[i]) begin
					rank_d[i] = RANK_W'(rank_q[i] + 1'b1);
				end
			end
			if (!do_evict) begin
				occupancy_d = OCC_W'(occupancy_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			occupancy_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			entry_valid_q <= entry_valid_d;
			occupancy_q <= occupancy_d;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (key_we[i]) begin
				entry_key_q[i] <= req_s1.key;
			end
			if (value_we[i]) begin
				entry_value_q[i] <= req_s1.value;
			end
		end
	end

	// Result word.
	always_comb begin
		result_d.hit = found;
		if (is_put) begin
			result_d.read_value = '0;
		end else if (found) begin
			result_d.read_value = found_value;
		end else begin
			result_d.read_value = READ_MISS;
		end
		result_d.evicted = do_evict;
		result_d.evicted_key = do_evict ? oldest_key : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
